[rtl/core/scp_pkg.sv]
package scp_pkg;

   localparam int TILE_UNITS_DEFAULT  = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int FRAC_BITS     = 16;
   localparam int PICKUP_MARGIN = 8;
   localparam int DIV_W         = 32;
   localparam int PERP_FLOOR    = 2048;
   localparam int HEIGHT_NUMER  = 240 << 16;
   localparam int HEIGHT_MAX    = 255;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_X    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Y    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_COS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_SIN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VISIBLE = 3'd4;

   typedef enum logic [1:0] {
      STATUS_PICKUP  = 2'd0,
      STATUS_BEHIND  = 2'd1,
      STATUS_VISIBLE = 2'd2,
      STATUS_DROPPED = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] camera_x;
      logic signed [31:0] camera_y;
      logic signed [17:0] view_cos;
      logic signed [17:0] view_sin;
      logic [7:0]         max_visible;
   } cfg_type;

   // One classified entity on its way from the front to the back.
   typedef struct packed {
      logic               frame_start;
      logic               pickup;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
   } entry_type;

endpackage

[rtl/core/scp_divider.sv]
module scp_divider #(
   parameter int WIDTH = scp_pkg::DIV_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] numer,
   input  logic [WIDTH-1:0] denom,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] quot_ff;
   logic [WIDTH-1:0] den_ff;

   logic [WIDTH:0]   shifted;
   logic [WIDTH+1:0] trial;

   // Restoring division, one quotient bit per cycle, most significant first.
   assign shifted = {rem_ff, quot_ff[WIDTH-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quot_ff <= numer;
         den_ff  <= denom;
      end else if (busy_ff) begin
         if (!trial[WIDTH+1]) begin
            rem_ff  <= trial[WIDTH-1:0];
            quot_ff <= {quot_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_ff  <= shifted[WIDTH-1:0];
            quot_ff <= {quot_ff[WIDTH-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

`ifndef SYNTHESIS
   a_busy_not_done: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff)
      else $error("divider reports done while still iterating");
`endif

endmodule

[rtl/core/scp_front.sv]
module scp_front #(
   parameter int TILE_UNITS = scp_pkg::TILE_UNITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  scp_pkg::cfg_type   cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic signed [31:0] entity_x,
   input  logic signed [31:0] entity_y,
   input  logic               frame_start,
   output logic               ent_valid,
   input  logic               ent_ready,
   output scp_pkg::entry_type ent
);

   localparam logic signed [31:0] PICKUP_LIMIT =
      32'((TILE_UNITS / 2 + scp_pkg::PICKUP_MARGIN) << scp_pkg::FRAC_BITS);
   localparam logic signed [31:0] PICKUP_NEG = -PICKUP_LIMIT;
   localparam logic signed [31:0] MOST_NEG   = 32'sh8000_0000;

   logic               hold_ff;
   scp_pkg::entry_type ent_ff;

   logic signed [31:0] dx;
   logic signed [31:0] dy;
   logic               near_x;
   logic               near_y;

   assign dx = entity_x - cfg.camera_x;
   assign dy = entity_y - cfg.camera_y;

   // The absolute value of the most negative offset wraps to itself, so it counts as near.
   assign near_x = (dx == MOST_NEG) || ((dx <= PICKUP_LIMIT) && (dx >= PICKUP_NEG));
   assign near_y = (dy == MOST_NEG) || ((dy <= PICKUP_LIMIT) && (dy >= PICKUP_NEG));

   assign req_tready = !hold_ff || ent_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         hold_ff            <= 1'b1;
         ent_ff.frame_start <= frame_start;
         ent_ff.pickup      <= near_x && near_y;
         ent_ff.dx          <= dx;
         ent_ff.dy          <= dy;
      end else if (ent_ready) begin
         hold_ff <= 1'b0;
      end
   end

   assign ent_valid = hold_ff;
   assign ent       = ent_ff;

endmodule

[rtl/core/scp_queue.sv]
module scp_queue #(
   parameter int DEPTH = scp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  scp_pkg::entry_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output scp_pkg::entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   scp_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   logic push;
   logic pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue holds more entries than it has slots");
`endif

endmodule

[rtl/core/scp_back.sv]
module scp_back #(
   parameter int TILE_UNITS = scp_pkg::TILE_UNITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  scp_pkg::cfg_type   cfg,
   input  logic               ent_valid,
   output logic               ent_ready,
   input  scp_pkg::entry_type ent,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [1:0]         rsp_tuser,
   output logic [55:0]        rsp_tdata
);

   localparam int W = scp_pkg::DIV_W;
   localparam logic [W-1:0] PERP_FLOOR   = W'(scp_pkg::PERP_FLOOR);
   localparam logic [W-1:0] HEIGHT_NUMER = W'(scp_pkg::HEIGHT_NUMER);
   localparam logic [W-1:0] HEIGHT_MAX   = W'(scp_pkg::HEIGHT_MAX);

   // Rounded-up reciprocal of the tile size; exact for every 32-bit numerator.
   localparam int          RECIP_SHIFT = 32 + $clog2(TILE_UNITS);
   localparam logic [32:0] RECIP =
      33'(((64'd1 << RECIP_SHIFT) + 64'(TILE_UNITS) - 64'd1) / 64'(TILE_UNITS));
   localparam logic [16:0] RECIP_LO = RECIP[16:0];
   localparam logic [15:0] RECIP_HI = RECIP[32:17];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_RGT,
      ST_DIVS,
      ST_DIV1,
      ST_DIV2,
      ST_OUT
   } state_type;

   state_type            state_ff;
   logic [7:0]           count_ff;
   scp_pkg::status_type  status_ff;
   logic signed [31:0]   dx_ff;
   logic signed [31:0]   dy_ff;
   logic signed [49:0]   prod_ff;
   logic signed [49:0]   acc_ff;
   logic signed [31:0]   fwd_ff;
   logic signed [31:0]   rgt_ff;
   logic [7:0]           height_ff;
   logic [23:0]          ox_ff;
   logic [23:0]          oy_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_user_ff;
   logic [55:0]          rsp_data_ff;
   logic [48:0]          tile_lo_ff;
   logic [47:0]          tile_hi_ff;

   logic [7:0]           count_eff;
   logic signed [31:0]   mul_a;
   logic signed [17:0]   mul_b;
   logic signed [49:0]   prod;
   logic [47:0]          fwd_sum;
   logic [47:0]          rgt_sum;
   logic                 rgt_neg;
   logic [W-1:0]         rgt_mag;
   logic [31:0]          tile_num;
   logic [64:0]          tile_prod;
   logic [31:0]          tile_quot;
   logic [W-1:0]         rgt_quot;
   logic [W-1:0]         perp;
   logic                 start_a;
   logic                 done_a;
   logic [W-1:0]         quot_a;

   // One shared 32 x 18 multiplier forms the four rotation products in turn.
   assign mul_a   = ((state_ff == ST_MUL0) || (state_ff == ST_MUL3)) ? dx_ff : dy_ff;
   assign mul_b   = ((state_ff == ST_MUL0) || (state_ff == ST_MUL2)) ? cfg.view_cos
                                                                     : cfg.view_sin;
   assign prod    = mul_a * mul_b;
   assign fwd_sum = acc_ff[47:0] + prod_ff[47:0];
   assign rgt_sum = acc_ff[47:0] - prod_ff[47:0];

   assign count_eff = ent.frame_start ? 8'd0 : count_ff;

   assign rgt_neg  = rgt_ff[31];
   assign rgt_mag  = rgt_neg ? W'(-rgt_ff) : W'(rgt_ff);

   // Division by the tile size multiplies by the reciprocal in two registered
   // halves, so the quotient follows in the cycle after the numerator. The depth
   // is presented in ST_DIVS and the sideways magnitude from then on.
   assign tile_num  = (state_ff == ST_DIVS) ? 32'(fwd_ff) : 32'(rgt_mag);
   assign tile_prod = {16'd0, tile_lo_ff} + {tile_hi_ff, 17'd0};
   assign tile_quot = 32'(tile_prod >> RECIP_SHIFT);

   assign rgt_quot = rgt_neg ? (~tile_quot + 1'b1) : tile_quot;
   assign perp     = (tile_quot <= PERP_FLOOR) ? PERP_FLOOR : tile_quot;

   assign start_a  = (state_ff == ST_DIV1);

   always_ff @(posedge clock) begin
      tile_lo_ff <= 49'(tile_num) * 49'(RECIP_LO);
      tile_hi_ff <= 48'(tile_num) * 48'(RECIP_HI);
   end

   scp_divider #(.WIDTH(W)) u_div_a (
      .clock    (clock),
      .reset    (reset),
      .start    (start_a),
      .numer    (HEIGHT_NUMER),
      .denom    (perp),
      .done     (done_a),
      .quotient (quot_a)
   );

   assign ent_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (ent_valid) begin
                  count_ff <= count_eff;
                  dx_ff    <= ent.dx;
                  dy_ff    <= ent.dy;
                  // The cap is checked ahead of the pickup test.
                  if (count_eff >= cfg.max_visible) begin
                     status_ff <= scp_pkg::STATUS_DROPPED;
                     state_ff  <= ST_OUT;
                  end else if (ent.pickup) begin
                     status_ff <= scp_pkg::STATUS_PICKUP;
                     state_ff  <= ST_OUT;
                  end else begin
                     state_ff <= ST_MUL0;
                  end
               end
            end
            ST_MUL0: begin
               prod_ff  <= prod;
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               acc_ff   <= prod_ff;
               prod_ff  <= prod;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               fwd_ff   <= fwd_sum[47:16];
               prod_ff  <= prod;
               state_ff <= ST_MUL3;
            end
            ST_MUL3: begin
               if (fwd_ff <= 0) begin
                  status_ff <= scp_pkg::STATUS_BEHIND;
                  state_ff  <= ST_OUT;
               end else begin
                  acc_ff   <= prod_ff;
                  prod_ff  <= prod;
                  state_ff <= ST_RGT;
               end
            end
            ST_RGT: begin
               rgt_ff   <= rgt_sum[47:16];
               state_ff <= ST_DIVS;
            end
            ST_DIVS: begin
               state_ff <= ST_DIV1;
            end
            ST_DIV1: begin
               oy_ff    <= tile_quot[31:8];
               state_ff <= ST_DIV2;
            end
            ST_DIV2: begin
               if (done_a) begin
                  ox_ff     <= rgt_quot[31:8];
                  height_ff <= (quot_a > HEIGHT_MAX) ? 8'(HEIGHT_MAX) : quot_a[7:0];
                  count_ff  <= count_ff + 1'b1;
                  status_ff <= scp_pkg::STATUS_VISIBLE;
                  state_ff  <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= status_ff;
                  if (status_ff == scp_pkg::STATUS_VISIBLE) begin
                     rsp_data_ff <= {oy_ff, ox_ff, height_ff};
                  end else begin
                     rsp_data_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_user_ff != scp_pkg::STATUS_VISIBLE)) |-> (rsp_data_ff == '0))
      else $error("result that is not visible carries nonzero values");

   a_depth_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_user_ff == scp_pkg::STATUS_VISIBLE)) |-> !rsp_data_ff[55])
      else $error("visible result has a negative depth offset");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ((count_ff == '0) || (count_ff == $past(count_ff) + 8'd1)))
      else $error("visible counter moved by something other than one step or a clear");
`endif

endmodule

[rtl/core/sprite_camera_projection.sv]
// Projects one entity position per transaction into camera space. The front
// stage subtracts the camera position and flags entities close enough to be
// picked up; a short queue then feeds the back stage, which applies the
// per-frame visible cap, rotates the offset with one shared 32 x 18
// multiplier (four products, one per cycle), divides depth and sideways
// offset by the tile size with a reciprocal multiplication and forms the
// apparent height with one bit-serial 32-bit divider. A dropped or picked-up
// entity goes straight out, one behind the camera after the multiply states,
// a visible one through the division states, where the height division sets
// the rate. Results leave through an output register, so the back stage
// starts the next entity while a result waits. Configuration writes are taken
// in every cycle and must only be made while no entity is in flight.
module sprite_camera_projection #(
   parameter int TILE_UNITS  = scp_pkg::TILE_UNITS_DEFAULT,
   parameter int QUEUE_DEPTH = scp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [63:0]                      req_tdata,  // entity_x, entity_y
   input  logic                             req_tuser,  // frame_start
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [55:0]                      rsp_tdata,  // apparent_height, screen_offset_x,
                                                        // screen_offset_y
   output logic [1:0]                       rsp_tuser,  // status
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [scp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [scp_pkg::CSR_DATA_W-1:0]   csr_data
);

   scp_pkg::cfg_type   cfg_ff;
   logic               ent_valid;
   logic               ent_ready;
   scp_pkg::entry_type ent;
   logic               q_valid;
   logic               q_ready;
   scp_pkg::entry_type q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x    <= '0;
         cfg_ff.camera_y    <= '0;
         cfg_ff.view_cos    <= 18'sd65536;
         cfg_ff.view_sin    <= '0;
         cfg_ff.max_visible <= 8'd255;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            scp_pkg::CSR_CAMERA_X:    cfg_ff.camera_x    <= csr_data;
            scp_pkg::CSR_CAMERA_Y:    cfg_ff.camera_y    <= csr_data;
            scp_pkg::CSR_VIEW_COS:    cfg_ff.view_cos    <= csr_data[17:0];
            scp_pkg::CSR_VIEW_SIN:    cfg_ff.view_sin    <= csr_data[17:0];
            scp_pkg::CSR_MAX_VISIBLE: cfg_ff.max_visible <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   scp_front #(.TILE_UNITS(TILE_UNITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .entity_x    (req_tdata[31:0]),
      .entity_y    (req_tdata[63:32]),
      .frame_start (req_tuser),
      .ent_valid   (ent_valid),
      .ent_ready   (ent_ready),
      .ent         (ent)
   );

   scp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (ent_valid),
      .push_ready (ent_ready),
      .push_data  (ent),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   scp_back #(.TILE_UNITS(TILE_UNITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .ent_valid  (q_valid),
      .ent_ready  (q_ready),
      .ent        (q_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[dv/tb_sprite_camera_projection.sv]
`timescale 1ns / 100ps

module tb_sprite_camera_projection;

   localparam int TILE = scp_pkg::TILE_UNITS_DEFAULT;
   localparam logic signed [31:0] PICKUP_LIMIT =
      (TILE / 2 + scp_pkg::PICKUP_MARGIN) << scp_pkg::FRAC_BITS;
   localparam int PHASES = 13;
   localparam int PHASE_ITEMS = 150;

   typedef struct {
      scp_pkg::status_type status;
      logic [7:0]          height;
      logic [23:0]         off_x;
      logic [23:0]         off_y;
   } projection_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [63:0]                     req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [55:0]                     rsp_tdata;
   logic [1:0]                      rsp_tuser;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [scp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [scp_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // Shadow copy of the camera registers and the per-frame counter.
   logic signed [31:0] cam_x = '0;
   logic signed [31:0] cam_y = '0;
   logic signed [17:0] view_cos = 18'sd65536;
   logic signed [17:0] view_sin = '0;
   logic [7:0]         max_vis = 8'd255;
   logic [7:0]         vis_count = '0;

   projection_type pending_projections[$];
   projection_type want;
   int             errors = 0;
   int             results_checked = 0;
   int             status_seen[4] = '{0, 0, 0, 0};
   int             stall_left = 0;
   bit             quiet = 1'b0;

   sprite_camera_projection dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic projection_type project_entity(input logic signed [31:0] ex,
                                                     input logic signed [31:0] ey,
                                                     input logic fs);
      projection_type     r = '{scp_pkg::STATUS_DROPPED, 8'd0, 24'd0, 24'd0};
      logic signed [31:0] dx, dy, adx, ady, fwd, rgt;
      longint             prod, depth, perp, height, side;
      if (fs) vis_count = 8'd0;
      // The cap is checked before anything else, so even a pickup is dropped.
      if (vis_count >= max_vis) return r;
      dx = ex - cam_x;
      dy = ey - cam_y;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      if (adx <= PICKUP_LIMIT && ady <= PICKUP_LIMIT) begin
         r.status = scp_pkg::STATUS_PICKUP;
         return r;
      end
      prod = longint'(dx) * longint'(view_cos) + longint'(dy) * longint'(view_sin);
      fwd = prod[47:16];
      if (fwd <= 0) begin
         r.status = scp_pkg::STATUS_BEHIND;
         return r;
      end
      prod = longint'(dy) * longint'(view_cos) - longint'(dx) * longint'(view_sin);
      rgt = prod[47:16];
      depth = longint'(fwd) / longint'(TILE);
      perp = (depth <= longint'(scp_pkg::PERP_FLOOR)) ? longint'(scp_pkg::PERP_FLOOR)
                                                      : depth;
      height = longint'(scp_pkg::HEIGHT_NUMER) / perp;
      if (height > longint'(scp_pkg::HEIGHT_MAX)) height = longint'(scp_pkg::HEIGHT_MAX);
      // Division truncates toward zero, then the shift floors.
      side = longint'(rgt) / longint'(TILE);
      r.status = scp_pkg::STATUS_VISIBLE;
      r.height = height[7:0];
      r.off_x = side[31:8];
      r.off_y = depth[31:8];
      vis_count = vis_count + 8'd1;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t: result %0d: %s", $realtime, results_checked, msg);
   endtask

   task automatic write_reg(input logic [scp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         scp_pkg::CSR_CAMERA_X:    cam_x = value;
         scp_pkg::CSR_CAMERA_Y:    cam_y = value;
         scp_pkg::CSR_VIEW_COS:    view_cos = value[17:0];
         scp_pkg::CSR_VIEW_SIN:    view_sin = value[17:0];
         scp_pkg::CSR_MAX_VISIBLE: max_vis = value[7:0];
         default: ;
      endcase
   endtask

   // Unused upper data bits are filled with noise; the block must ignore them.
   task automatic configure(input logic [31:0] cx, input logic [31:0] cy,
                            input int cosv, input int sinv, input int maxv);
      write_reg(scp_pkg::CSR_CAMERA_X, cx);
      write_reg(scp_pkg::CSR_CAMERA_Y, cy);
      write_reg(scp_pkg::CSR_VIEW_COS, {14'($urandom), 18'(cosv)});
      write_reg(scp_pkg::CSR_VIEW_SIN, {14'($urandom), 18'(sinv)});
      write_reg(scp_pkg::CSR_MAX_VISIBLE, {24'($urandom), 8'(maxv)});
   endtask

   task automatic send_entity(input logic [31:0] ex, input logic [31:0] ey, input logic fs);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ey, ex};
      req_tuser  <= fs;
      do @(posedge clock); while (!req_tready);
      pending_projections.push_back(project_entity(ex, ey, fs));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_projections.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] random_span();
      logic [31:0] v = $urandom >> $urandom_range(1, 12);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   task automatic send_random_entity(input logic fs);
      logic [31:0] a, b;
      int          mode = $urandom_range(0, 99);
      if (mode < 50) begin
         a = random_span();
         b = random_span();
      end else if (mode < 65) begin
         // One axis sits just inside, on, or just outside the pickup range.
         a = PICKUP_LIMIT + $urandom_range(0, 2) - 1;
         b = $urandom_range(0, PICKUP_LIMIT + 1);
         if ($urandom_range(0, 1)) a = -a;
         if ($urandom_range(0, 1)) b = -b;
         if ($urandom_range(0, 1)) {a, b} = {b, a};
      end else if (mode < 80) begin
         a = $urandom_range(0, PICKUP_LIMIT);
         b = $urandom_range(0, PICKUP_LIMIT);
         if ($urandom_range(0, 1)) a = -a;
         if ($urandom_range(0, 1)) b = -b;
      end else begin
         a = $urandom - cam_x;
         b = $urandom - cam_y;
      end
      send_entity(cam_x + a, cam_y + b, fs);
   endtask

   // Reset values apply here: camera at the origin looking along +x.
   task automatic test_directed_cases();
      send_entity(32'd0, 32'd0, 1'b1);
      send_entity(PICKUP_LIMIT, -PICKUP_LIMIT, 1'b0);
      send_entity(PICKUP_LIMIT + 1, 32'd0, 1'b0);
      send_entity(-(PICKUP_LIMIT + 1), 32'd0, 1'b0);
      send_entity(32'd0, PICKUP_LIMIT + 1, 1'b0);
      send_entity(32'h8000_0000, 32'd0, 1'b0);
      send_entity(32'h8000_0000, 32'h8000_0000, 1'b1);
      send_entity(32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_entity(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
      send_entity(32'd10066304, -32'd5000000, 1'b0);
      send_entity(32'd3947648, 32'd0, 1'b0);
      send_entity(32'd3947584, 32'd0, 1'b1);
      send_entity(32'd5000000, 32'hffff_ffff, 1'b0);
      send_entity(32'd5000000, -32'd16383, 1'b0);
      send_entity(32'hffff_ffff, 32'hffff_ffff, 1'b0);
      send_entity(32'h4000_0000, 32'hc000_0000, 1'b0);
      wait_idle();
   endtask

   task automatic test_visible_cap();
      configure(32'd0, 32'd0, 65536, 0, 2);
      send_entity(32'd5000000, 32'd0, 1'b1);
      send_entity(32'd6000000, 32'd0, 1'b0);
      send_entity(32'd7000000, 32'd0, 1'b0);
      send_entity(32'd0, 32'd0, 1'b0);
      send_entity(32'd8000000, 32'd0, 1'b1);
      wait_idle();
      configure(32'd0, 32'd0, 65536, 0, 0);
      send_entity(32'd5000000, 32'd0, 1'b1);
      send_entity(32'd0, 32'd0, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_phases();
      int frame_left;
      int cosv, sinv;
      for (int phase = 0; phase < PHASES; phase++) begin
         quiet = (phase >= PHASES - 2);
         case (phase)
            0: configure(32'd0, 32'd0, 65536, 0, 255);
            1: configure(32'h7fff_ffff, 32'h8000_0000, -65536, 0, 255);
            2: configure($urandom, $urandom, 0, 65536, 4);
            3: configure($urandom, $urandom, 0, -65536, 1);
            4: configure($urandom, $urandom, 46341, 46341, 0);
            5: configure($urandom, $urandom, 131071, -131072, 255);
            default: begin
               cosv = $urandom_range(0, 65536);
               sinv = $urandom_range(0, 65536);
               if ($urandom_range(0, 1)) cosv = -cosv;
               if ($urandom_range(0, 1)) sinv = -sinv;
               configure($urandom, $urandom, cosv, sinv,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(1, 10));
            end
         endcase
         frame_left = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Now and then hold off until every outstanding transaction has drained.
            if (n == PHASE_ITEMS / 2 && phase % 3 == 0) wait_idle();
            if (frame_left == 0) begin
               frame_left = $urandom_range(1, 12);
               send_random_entity(1'b1);
            end else begin
               send_random_entity($urandom_range(0, 19) == 0);
            end
            frame_left--;
         end
         wait_idle();
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_projections.size() == 0) begin
            report_mismatch("result arrived with no projection pending");
         end else begin
            want = pending_projections.pop_front();
            status_seen[want.status]++;
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("status got %0d, expected %0d",
                                         rsp_tuser, want.status));
            if (rsp_tdata[7:0] !== want.height)
               report_mismatch($sformatf("apparent_height got %0d, expected %0d",
                                         rsp_tdata[7:0], want.height));
            if (rsp_tdata[31:8] !== want.off_x)
               report_mismatch($sformatf("screen_offset_x got %h, expected %h",
                                         rsp_tdata[31:8], want.off_x));
            if (rsp_tdata[55:32] !== want.off_y)
               report_mismatch($sformatf("screen_offset_y got %h, expected %h",
                                         rsp_tdata[55:32], want.off_y));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d projections outstanding.", pending_projections.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_visible_cap();
      test_random_phases();
      $display("Checked %0d projections across %0d camera settings plus directed cases.",
               results_checked, PHASES);
      $display("Outcomes: %0d picked up, %0d behind, %0d visible, %0d dropped by cap.",
               status_seen[scp_pkg::STATUS_PICKUP], status_seen[scp_pkg::STATUS_BEHIND],
               status_seen[scp_pkg::STATUS_VISIBLE], status_seen[scp_pkg::STATUS_DROPPED]);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
